[sv/hsv_color_interpolator_core_macros.svh]
// Assertion macros for the HSV color interpolator
`ifndef HSV_COLOR_INTERPOLATOR_CORE_MACROS_SVH
`define HSV_COLOR_INTERPOLATOR_CORE_MACROS_SVH
// implication checked at every clock, held off during reset
`define HCI_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
// next-cycle implication
`define HCI_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`endif

[sv/hci_pkg.sv]
// Package: widths, constants and types for the HSV interpolator
package hci_pkg;
   localparam int FRACTION_BITS_DEFAULT = 8;
   localparam int LANE_DEPTH = 6;
   localparam int LATENCY = 9;
   localparam logic [7:0] HUE_RED   = 8'd0;
   localparam logic [7:0] HUE_GREEN = 8'd85;
   localparam logic [7:0] HUE_BLUE  = 8'd171;
   localparam logic [7:0] SECTOR    = 8'd43;

   typedef struct packed {
      logic [7:0] h;
      logic [7:0] s;
      logic [7:0] v;
   } hsv_type;

   typedef enum logic [2:0] {
      REG_0 = 3'd0, REG_1 = 3'd1, REG_2 = 3'd2,
      REG_3 = 3'd3, REG_4 = 3'd4, REG_5 = 3'd5
   } region_type;
endpackage

[sv/hci_div.sv]
// Restoring divider stage: two quotient bits of num/den per clock, registered
module hci_div (
   input  logic       clock,
   input  logic [7:0] rem_i,
   input  logic [7:0] num_i,
   input  logic [7:0] quo_i,
   input  logic [7:0] den_i,
   output logic [7:0] rem_o,
   output logic [7:0] num_o,
   output logic [7:0] quo_o,
   output logic [7:0] den_o
);
   // partial remainder stays below den, so nine bits hold each trial
   logic [8:0] sh_a, trial_a, sh_b, trial_b;
   logic [7:0] rem_a, rem_b;
   logic       q_a, q_b;
   always_comb begin
      sh_a    = {rem_i, num_i[7]};
      trial_a = sh_a - {1'b0, den_i};
      q_a     = ~trial_a[8];
      rem_a   = q_a ? trial_a[7:0] : sh_a[7:0];
      sh_b    = {rem_a, num_i[6]};
      trial_b = sh_b - {1'b0, den_i};
      q_b     = ~trial_b[8];
      rem_b   = q_b ? trial_b[7:0] : sh_b[7:0];
   end

   logic [7:0] rem_ff, num_ff, quo_ff, den_ff;
   always_ff @(posedge clock) begin
      rem_ff <= rem_b;
      num_ff <= {num_i[5:0], 2'b00};
      quo_ff <= {quo_i[5:0], q_a, q_b};
      den_ff <= den_i;
   end

   assign rem_o = rem_ff;
   assign num_o = num_ff;
   assign quo_o = quo_ff;
   assign den_o = den_ff;
endmodule

[sv/hci_lane.sv]
// One color lane: RGB to HSV conversion, pipelined over stages
module hci_lane (
   input  logic                clock,
   input  logic [7:0]          red,
   input  logic [7:0]          green,
   input  logic [7:0]          blue,
   output hci_pkg::hsv_type    hsv
);
   localparam int DIV_STAGES = 4;

   // stage 1: min, max, signed difference, base
   logic [7:0] hi_ff, span_ff, base_ff;
   logic [7:0] dmag_ff;
   logic       dneg_ff;
   logic [7:0] lo, hi;
   logic [7:0] dmag_in, base_in;
   logic       dneg_in;
   logic [8:0] d;

   always_comb begin
      lo = (red < green) ? ((red < blue) ? red : blue) : ((green < blue) ? green : blue);
      hi = (red > green) ? ((red > blue) ? red : blue) : ((green > blue) ? green : blue);
      priority if (hi == red) begin
         base_in = hci_pkg::HUE_RED;
         d = {1'b0, green} - {1'b0, blue};
      end else if (hi == green) begin
         base_in = hci_pkg::HUE_GREEN;
         d = {1'b0, blue} - {1'b0, red};
      end else begin
         base_in = hci_pkg::HUE_BLUE;
         d = {1'b0, red} - {1'b0, green};
      end
      dneg_in = d[8];
      dmag_in = d[8] ? 8'(-d) : d[7:0];
   end

   always_ff @(posedge clock) begin
      hi_ff   <= hi;
      span_ff <= hi - lo;
      base_ff <= base_in;
      dmag_ff <= dmag_in;
      dneg_ff <= dneg_in;
   end

   // stage 2: numerators 255*span and 43*|diff|
   logic [15:0] sn_ff, hn_ff;
   logic [7:0]  hi2_ff, span2_ff, base2_ff;
   logic        dneg2_ff;
   always_ff @(posedge clock) begin
      sn_ff    <= {span_ff, 8'd0} - {8'd0, span_ff};
      hn_ff    <= 16'(dmag_ff) * 16'(hci_pkg::SECTOR);
      hi2_ff   <= hi_ff;
      span2_ff <= span_ff;
      base2_ff <= base_ff;
      dneg2_ff <= dneg_ff;
   end

   // stages 3 to 6: two dividers, two quotient bits per stage
   // numerator is below 256*den, so the high byte starts as the remainder
   logic [7:0] s_rem [DIV_STAGES+1];
   logic [7:0] s_num [DIV_STAGES+1];
   logic [7:0] s_quo [DIV_STAGES+1];
   logic [7:0] s_den [DIV_STAGES+1];
   logic [7:0] h_rem [DIV_STAGES+1];
   logic [7:0] h_num [DIV_STAGES+1];
   logic [7:0] h_quo [DIV_STAGES+1];
   logic [7:0] h_den [DIV_STAGES+1];
   assign s_rem[0] = sn_ff[15:8];
   assign s_num[0] = sn_ff[7:0];
   assign s_quo[0] = '0;
   assign s_den[0] = hi2_ff;
   assign h_rem[0] = hn_ff[15:8];
   assign h_num[0] = hn_ff[7:0];
   assign h_quo[0] = '0;
   assign h_den[0] = span2_ff;
   for (genvar k = 0; k < DIV_STAGES; k++) begin : g_div
      hci_div u_sdiv (.clock(clock), .rem_i(s_rem[k]), .num_i(s_num[k]),
         .quo_i(s_quo[k]), .den_i(s_den[k]), .rem_o(s_rem[k+1]),
         .num_o(s_num[k+1]), .quo_o(s_quo[k+1]), .den_o(s_den[k+1]));
      hci_div u_hdiv (.clock(clock), .rem_i(h_rem[k]), .num_i(h_num[k]),
         .quo_i(h_quo[k]), .den_i(h_den[k]), .rem_o(h_rem[k+1]),
         .num_o(h_num[k+1]), .quo_o(h_quo[k+1]), .den_o(h_den[k+1]));
   end

   // hue base and sign ride beside the dividers
   logic [7:0] base_d_ff [DIV_STAGES];
   logic       dneg_d_ff [DIV_STAGES];
   always_ff @(posedge clock) begin
      base_d_ff[0] <= base2_ff;
      dneg_d_ff[0] <= dneg2_ff;
      for (int k = 1; k < DIV_STAGES; k++) begin
         base_d_ff[k] <= base_d_ff[k-1];
         dneg_d_ff[k] <= dneg_d_ff[k-1];
      end
   end

   // black and gray force hue and saturation to zero
   logic blk;
   assign blk = (s_den[DIV_STAGES] == 8'd0);
   always_comb begin
      hsv.v = s_den[DIV_STAGES];
      hsv.s = blk ? 8'd0 : s_quo[DIV_STAGES];
      hsv.h = (blk || s_quo[DIV_STAGES] == 8'd0) ? 8'd0 :
              (dneg_d_ff[DIV_STAGES-1] ? base_d_ff[DIV_STAGES-1] - h_quo[DIV_STAGES]
                                       : base_d_ff[DIV_STAGES-1] + h_quo[DIV_STAGES]);
   end
endmodule

[sv/hci_merge.sv]
// Merge stage: blends the two lane results and converts back to RGB
module hci_merge #(
   parameter int FRACTION_BITS = hci_pkg::FRACTION_BITS_DEFAULT
) (
   input  logic                   clock,
   input  hci_pkg::hsv_type       hsv_a,
   input  hci_pkg::hsv_type       hsv_b,
   input  logic [FRACTION_BITS:0] frac,
   output logic [7:0]             red,
   output logic [7:0]             green,
   output logic [7:0]             blue
);
   localparam int FW = FRACTION_BITS + 1;
   localparam int PW = FW + 8;
   localparam logic [FW-1:0] ONE = FW'(1) << FRACTION_BITS;

   // stage 1: blend three channels
   logic [PW-1:0] bh, bs, bv;
   logic [FW-1:0] inv;
   assign inv = ONE - frac;
   assign bh = PW'(hsv_a.h) * PW'(inv) + PW'(hsv_b.h) * PW'(frac);
   assign bs = PW'(hsv_a.s) * PW'(inv) + PW'(hsv_b.s) * PW'(frac);
   assign bv = PW'(hsv_a.v) * PW'(inv) + PW'(hsv_b.v) * PW'(frac);

   logic [7:0] h_ff, s_ff, v_ff;
   always_ff @(posedge clock) begin
      h_ff <= bh[FRACTION_BITS +: 8];
      s_ff <= bs[FRACTION_BITS +: 8];
      v_ff <= bv[FRACTION_BITS +: 8];
   end

   // stage 2: region, remainder, inner products
   logic [2:0] reg_w;
   logic [7:0] rem_w;
   always_comb begin
      priority if (h_ff >= 8'd215) reg_w = 3'd5;
      else if (h_ff >= 8'd172) reg_w = 3'd4;
      else if (h_ff >= 8'd129) reg_w = 3'd3;
      else if (h_ff >= 8'd86)  reg_w = 3'd2;
      else if (h_ff >= 8'd43)  reg_w = 3'd1;
      else                     reg_w = 3'd0;
      rem_w = 8'((h_ff - 8'(reg_w) * 8'd43) * 8'd6);
   end
   logic [15:0] sq_w, st_w;
   assign sq_w = 16'(s_ff) * 16'(rem_w);
   assign st_w = 16'(s_ff) * 16'(8'd255 - rem_w);

   hci_pkg::region_type rg_ff;
   logic [7:0] s2_ff, v2_ff, qi_ff, ti_ff;
   always_ff @(posedge clock) begin
      rg_ff <= hci_pkg::region_type'(reg_w);
      s2_ff <= s_ff;
      v2_ff <= v_ff;
      qi_ff <= 8'd255 - sq_w[15:8];
      ti_ff <= 8'd255 - st_w[15:8];
   end

   // stage 3: outer products and sector select
   logic [15:0] pp, qp, tp;
   logic [7:0]  p, q, t, r_w, g_w, b_w;
   always_comb begin
      pp = 16'(v2_ff) * 16'(8'd255 - s2_ff);
      qp = 16'(v2_ff) * 16'(qi_ff);
      tp = 16'(v2_ff) * 16'(ti_ff);
      p = pp[15:8];
      q = qp[15:8];
      t = tp[15:8];
      unique case (rg_ff)
         hci_pkg::REG_0: begin r_w = v2_ff; g_w = t; b_w = p; end
         hci_pkg::REG_1: begin r_w = q; g_w = v2_ff; b_w = p; end
         hci_pkg::REG_2: begin r_w = p; g_w = v2_ff; b_w = t; end
         hci_pkg::REG_3: begin r_w = p; g_w = q; b_w = v2_ff; end
         hci_pkg::REG_4: begin r_w = t; g_w = p; b_w = v2_ff; end
         default:        begin r_w = v2_ff; g_w = p; b_w = q; end
      endcase
      if (s2_ff == 8'd0) begin
         r_w = v2_ff; g_w = v2_ff; b_w = v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      red   <= r_w;
      green <= g_w;
      blue  <= b_w;
   end
endmodule

[sv/hsv_color_interpolator_core.sv]
// Top level of the HSV color interpolator: two conversion lanes and a merge stage
// Throughput: one beat per cycle; busy is tied low, the pipeline never stalls.
// Depth is set by the conversion lane (6 stages: extremes, numerators, four divider
// stages at two quotient bits each) plus the merge stage (3 stages: blend, inner
// products, outer products). Reset clears only the valid pipeline.
module hsv_color_interpolator_core #(
   parameter int FRACTION_BITS = hci_pkg::FRACTION_BITS_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  logic [7:0]             req_from_red,
   input  logic [7:0]             req_from_green,
   input  logic [7:0]             req_from_blue,
   input  logic [7:0]             req_to_red,
   input  logic [7:0]             req_to_green,
   input  logic [7:0]             req_to_blue,
   input  logic [FRACTION_BITS:0] req_fraction,
   output logic                   rsp_valid,
   output logic [7:0]             rsp_out_red,
   output logic [7:0]             rsp_out_green,
   output logic [7:0]             rsp_out_blue
);
   localparam int FW = FRACTION_BITS + 1;
   localparam logic [FW-1:0] ONE = FW'(1) << FRACTION_BITS;

   assign busy = 1'b0;

   // clamp fraction, delay it to meet lane outputs
   logic [FW-1:0] frac_ff [hci_pkg::LANE_DEPTH];
   always_ff @(posedge clock) begin
      frac_ff[0] <= (req_fraction > ONE) ? ONE : req_fraction;
      for (int k = 1; k < hci_pkg::LANE_DEPTH; k++) begin
         frac_ff[k] <= frac_ff[k-1];
      end
   end

   hci_pkg::hsv_type hsv_a, hsv_b;
   hci_lane u_lane_a (.clock(clock), .red(req_from_red), .green(req_from_green),
      .blue(req_from_blue), .hsv(hsv_a));
   hci_lane u_lane_b (.clock(clock), .red(req_to_red), .green(req_to_green),
      .blue(req_to_blue), .hsv(hsv_b));

   hci_merge #(.FRACTION_BITS(FRACTION_BITS)) u_merge (.clock(clock), .hsv_a(hsv_a),
      .hsv_b(hsv_b), .frac(frac_ff[hci_pkg::LANE_DEPTH-1]), .red(rsp_out_red),
      .green(rsp_out_green), .blue(rsp_out_blue));

   // valid pipeline
   logic [hci_pkg::LATENCY-1:0] vld_ff, vld_in;
   assign vld_in = {vld_ff[hci_pkg::LATENCY-2:0], start & ~busy};
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end
   assign rsp_valid = vld_ff[hci_pkg::LATENCY-1];
endmodule

[sv/hci_checker.sv]
// Port-level checker for the HSV color interpolator, bound to the top level
`include "hsv_color_interpolator_core_macros.svh"
module hci_checker (
   input logic       clock,
   input logic       reset,
   input logic       start,
   input logic       busy,
   input logic       rsp_valid,
   input logic [7:0] rsp_out_red,
   input logic [7:0] rsp_out_green,
   input logic [7:0] rsp_out_blue
);
   logic                        beat_in;
   logic                        quiet;
   logic [23:0]                 rsp_word;
   logic [hci_pkg::LATENCY-1:0] rst_hist_ff;

   assign beat_in  = start && !busy;
   assign rsp_word = {rsp_out_red, rsp_out_green, rsp_out_blue};

   // reset seen anywhere in the response latency window
   always_ff @(posedge clock) begin
      rst_hist_ff <= {rst_hist_ff[hci_pkg::LATENCY-2:0], reset};
   end
   assign quiet = (rst_hist_ff == '0);

   // no beat out without a beat in a full latency earlier
   `HCI_ASSERT_IMP(a_no_spurious, clock, reset, rsp_valid, $past(beat_in, hci_pkg::LATENCY))
   // each accepted beat yields a response a full latency later
   `HCI_ASSERT_IMP(a_resp_follows, clock, reset, $past(beat_in, hci_pkg::LATENCY) && quiet, rsp_valid)
   // pipeline never stalls
   `HCI_ASSERT_IMP(a_never_busy, clock, reset, 1'b1, !busy)
   // result beats carry known data
   `HCI_ASSERT_IMP(a_known_out, clock, reset, rsp_valid, !$isunknown(rsp_word))
endmodule

bind hsv_color_interpolator_core hci_checker u_hci_checker (
   .clock(clock), .reset(reset), .start(start), .busy(busy), .rsp_valid(rsp_valid),
   .rsp_out_red(rsp_out_red), .rsp_out_green(rsp_out_green), .rsp_out_blue(rsp_out_blue)
);

[tb/sv/hsv_color_interpolator_core_checker.sv]
// Checker for the HSV color interpolator: predicts each blended color and compares
`timescale 1ns / 100ps
module hsv_color_interpolator_core_checker #(
   parameter int FRACTION_BITS = hci_pkg::FRACTION_BITS_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic                   busy,
   input  logic [7:0]             req_from_red,
   input  logic [7:0]             req_from_green,
   input  logic [7:0]             req_from_blue,
   input  logic [7:0]             req_to_red,
   input  logic [7:0]             req_to_green,
   input  logic [7:0]             req_to_blue,
   input  logic [FRACTION_BITS:0] req_fraction,
   input  logic                   rsp_valid,
   input  logic [7:0]             rsp_out_red,
   input  logic [7:0]             rsp_out_green,
   input  logic [7:0]             rsp_out_blue,
   output int                     fail_count,
   output int                     pending
);
   typedef struct packed {
      logic [7:0] r;
      logic [7:0] g;
      logic [7:0] b;
   } rgb_type;

   localparam int UNITY = 1 << FRACTION_BITS;

   rgb_type color_queue[$];

   // integer RGB to HSV
   function automatic hci_pkg::hsv_type rgb_to_hsv(input rgb_type c);
      hci_pkg::hsv_type o;
      int lo, hi, span, diff, base;
      lo = int'(c.r); hi = int'(c.r);
      if (int'(c.g) < lo) lo = int'(c.g);
      if (int'(c.b) < lo) lo = int'(c.b);
      if (int'(c.g) > hi) hi = int'(c.g);
      if (int'(c.b) > hi) hi = int'(c.b);
      o.v = 8'(hi); o.h = '0; o.s = '0;
      if (hi != 0) begin
         o.s = 8'((255 * (hi - lo)) / hi);
         if (o.s != 8'd0) begin
            span = hi - lo;
            if (hi == int'(c.r)) begin
               base = int'(hci_pkg::HUE_RED); diff = int'(c.g) - int'(c.b);
            end else if (hi == int'(c.g)) begin
               base = int'(hci_pkg::HUE_GREEN); diff = int'(c.b) - int'(c.r);
            end else begin
               base = int'(hci_pkg::HUE_BLUE); diff = int'(c.r) - int'(c.g);
            end
            // SV integer division truncates toward zero
            o.h = 8'(base + (int'(hci_pkg::SECTOR) * diff) / span);
         end
      end
      return o;
   endfunction

   function automatic logic [7:0] mix(input int a, input int b, input int f);
      return 8'((a * (UNITY - f) + b * f) >> FRACTION_BITS);
   endfunction

   // HSV back to RGB, gray passes through
   function automatic rgb_type hsv_to_rgb(input hci_pkg::hsv_type c);
      rgb_type o;
      int v, s, region, rem;
      logic [7:0] p, q, t;
      v = int'(c.v); s = int'(c.s);
      if (s == 0) return '{c.v, c.v, c.v};
      region = int'(c.h) / int'(hci_pkg::SECTOR);
      rem = (int'(c.h) - region * int'(hci_pkg::SECTOR)) * 6;
      p = 8'((v * (255 - s)) >> 8);
      q = 8'((v * (255 - ((s * rem) >> 8))) >> 8);
      t = 8'((v * (255 - ((s * (255 - rem)) >> 8))) >> 8);
      unique case (region)
         0: o = '{c.v, t, p};
         1: o = '{q, c.v, p};
         2: o = '{p, c.v, t};
         3: o = '{p, q, c.v};
         4: o = '{t, p, c.v};
         default: o = '{c.v, p, q};
      endcase
      return o;
   endfunction

   function automatic rgb_type blend_colors(input rgb_type a, input rgb_type b,
                                            input int f);
      hci_pkg::hsv_type ha, hb, hm;
      ha = rgb_to_hsv(a);
      hb = rgb_to_hsv(b);
      if (f > UNITY) f = UNITY;
      hm.h = mix(int'(ha.h), int'(hb.h), f);
      hm.s = mix(int'(ha.s), int'(hb.s), f);
      hm.v = mix(int'(ha.v), int'(hb.v), f);
      return hsv_to_rgb(hm);
   endfunction

   assign pending = color_queue.size();

   // predict on accepted beats, compare on result strobes
   always @(posedge clock) begin
      rgb_type want;
      int errs;
      errs = 0;
      if (reset) begin
         fail_count <= 0;
      end else begin
         if (start && !busy)
            color_queue.push_back(blend_colors(
               '{req_from_red, req_from_green, req_from_blue},
               '{req_to_red, req_to_green, req_to_blue}, int'(req_fraction)));
         if (rsp_valid) begin
            if (color_queue.size() == 0) begin
               $error("unexpected result beat");
               errs++;
            end else begin
               want = color_queue.pop_front();
               if (rsp_out_red !== want.r) begin
                  $error("out_red: expected %0d, got %0d", want.r, rsp_out_red);
                  errs++;
               end
               if (rsp_out_green !== want.g) begin
                  $error("out_green: expected %0d, got %0d", want.g, rsp_out_green);
                  errs++;
               end
               if (rsp_out_blue !== want.b) begin
                  $error("out_blue: expected %0d, got %0d", want.b, rsp_out_blue);
                  errs++;
               end
            end
         end
         if (errs != 0)
            fail_count <= fail_count + errs;
      end
   end
endmodule

[tb/sv/hsv_color_interpolator_core_tb.sv]
// Testbench top for the HSV color interpolator: stimulus and verdict
`timescale 1ns / 100ps
module hsv_color_interpolator_core_tb;
   localparam int FB = hci_pkg::FRACTION_BITS_DEFAULT;
   localparam int RANDOM_BEATS = 1950;

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          start = 1'b0;
   logic          busy;
   logic [7:0]    from_red = '0, from_green = '0, from_blue = '0;
   logic [7:0]    to_red = '0, to_green = '0, to_blue = '0;
   logic [FB:0]   fraction = '0;
   logic          rsp_valid;
   logic [7:0]    out_red, out_green, out_blue;
   int            fail_count, pending;

   always #2 clock = ~clock;

   hsv_color_interpolator_core #(.FRACTION_BITS(FB)) uut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_from_red(from_red), .req_from_green(from_green), .req_from_blue(from_blue),
      .req_to_red(to_red), .req_to_green(to_green), .req_to_blue(to_blue),
      .req_fraction(fraction), .rsp_valid(rsp_valid),
      .rsp_out_red(out_red), .rsp_out_green(out_green), .rsp_out_blue(out_blue)
   );

   hsv_color_interpolator_core_checker #(.FRACTION_BITS(FB)) checker_i (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_from_red(from_red), .req_from_green(from_green), .req_from_blue(from_blue),
      .req_to_red(to_red), .req_to_green(to_green), .req_to_blue(to_blue),
      .req_fraction(fraction), .rsp_valid(rsp_valid),
      .rsp_out_red(out_red), .rsp_out_green(out_green), .rsp_out_blue(out_blue),
      .fail_count(fail_count), .pending(pending)
   );

   // drive one beat and hold it until accepted; an idle gap of gap_len comes first
   task automatic send_beat(input logic [23:0] a, input logic [23:0] b,
                            input logic [FB:0] f, input int gap_len);
      if (gap_len > 0) begin
         start <= 1'b0;
         repeat (gap_len) @(posedge clock);
      end
      start <= 1'b1;
      {from_red, from_green, from_blue} <= a;
      {to_red, to_green, to_blue} <= b;
      fraction <= f;
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 55) return 0;
      if (roll < 92) return $urandom_range(1, 3);
      return $urandom_range(4, 30);
   endfunction

   // random color: mostly free, some gray, some with one extreme channel
   function automatic logic [23:0] pick_color();
      logic [7:0] g;
      unique case ($urandom_range(0, 5))
         0: begin
            g = 8'($urandom);
            return {g, g, g};
         end
         1: return {8'($urandom_range(0, 1) * 255), 8'($urandom), 8'($urandom)};
         default: return 24'($urandom);
      endcase
   endfunction

   function automatic logic [FB:0] pick_fraction();
      unique case ($urandom_range(0, 9))
         0: return '0;
         1: return (FB + 1)'(1 << FB);
         2: return (FB + 1)'($urandom_range((1 << FB) + 1, (2 << FB) - 1));
         default: return (FB + 1)'($urandom_range(0, 1 << FB));
      endcase
   endfunction

   initial begin
      int burst;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: extremes, gray, black, each hue sector, over-unity fraction
      send_beat(24'h000000, 24'hFFFFFF, 9'd0, 0);
      send_beat(24'h000000, 24'hFFFFFF, 9'd256, 0);
      send_beat(24'h000000, 24'hFFFFFF, 9'd128, 0);
      send_beat(24'hFF0000, 24'h00FF00, 9'd128, 0);
      send_beat(24'h00FF00, 24'h0000FF, 9'd77, 0);
      send_beat(24'h0000FF, 24'hFF00FF, 9'd200, 0);
      send_beat(24'hFF00FF, 24'hFF0001, 9'd255, 0);
      send_beat(24'hFFFF00, 24'h00FFFF, 9'd1, 0);
      send_beat(24'h808080, 24'h404040, 9'd100, 0);
      send_beat(24'hFF0080, 24'hFF00C0, 9'd300, 0);
      send_beat(24'h123456, 24'hFEDCBA, 9'd511, 0);
      send_beat(24'hFF00FF, 24'hFF00FF, 9'd257, 0);
      send_beat(24'hFF0010, 24'hFF0010, 9'd0, 0);
      send_beat(24'h0100FF, 24'hAAAAAB, 9'd64, 0);
      send_beat(24'hFFFFFF, 24'h000000, 9'd192, 0);
      send_beat(24'h010000, 24'h000001, 9'd170, 0);

      // hold off until the pipeline has drained
      start <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);

      // random traffic, with stretches of back-to-back beats
      burst = 0;
      for (int i = 0; i < RANDOM_BEATS; i++) begin
         if (burst > 0) burst--;
         else if ($urandom_range(0, 19) == 0) burst = $urandom_range(20, 80);
         send_beat(pick_color(), pick_color(), pick_fraction(),
                   burst > 0 ? 0 : pick_gap());
      end
      start <= 1'b0;

      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (hci_pkg::LATENCY + 10) @(posedge clock);
      if (fail_count == 0)
         $display("** hsv_color_interpolator_core: PASSED **");
      else
         $display("** hsv_color_interpolator_core: FAILED **");
      $finish;
   end

   // watchdog
   initial begin
      #2000000;
      $display("** hsv_color_interpolator_core: FAILED **");
      $finish;
   end
endmodule
